// ===== rtl/mwm_pkg.sv =====
`timescale 1ns / 1ps

package mwm_pkg;

  localparam int          REG_DEADBAND   = 0;
  localparam logic [14:0] DEADBAND_RESET = 15'd4915;
  localparam int          AXIS_W         = 16;
  localparam int          QUEUE_DEPTH    = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // magnitude width of 1.5 - throttle
  function automatic int num_mag_w(input int frac);
    return max_int(frac + 1, AXIS_W) + 1;
  endfunction

  // magnitude width of a scaled axis
  function automatic int quot_w(input int frac);
    return AXIS_W + num_mag_w(frac) + 2 - frac - 2;
  endfunction

  // signed width of a mixed wheel value
  function automatic int wheel_w(input int frac);
    return quot_w(frac) + 3;
  endfunction

endpackage

// ===== rtl/mwm_queue.sv =====
`timescale 1ns / 1ps

module mwm_queue #(
  parameter int W = 84
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [W-1:0]         wdata,
  input  logic                 pop,
  output logic [W-1:0]         rdata,
  output mwm_pkg::queue_stat_t stat
);
  import mwm_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [IW-1:0] wptr;
  logic [IW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (count == CW'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == IW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == IW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mwm_front.sv =====
`timescale 1ns / 1ps

module mwm_front #(
  parameter  int FRAC_BITS = 15,
  localparam int WW = mwm_pkg::wheel_w(FRAC_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   stick_x,
  input  logic signed [15:0]   stick_y,
  input  logic signed [15:0]   stick_twist,
  input  logic signed [15:0]   throttle,
  input  logic [14:0]          deadband,
  input  mwm_pkg::queue_stat_t qstat,
  output logic                 push,
  output logic [3:0][WW-1:0]   wheel
);
  import mwm_pkg::*;

  localparam int NM_W = num_mag_w(FRAC_BITS);
  localparam int P_W  = AXIS_W + NM_W + 1;
  localparam int UW   = P_W + 1 - FRAC_BITS;
  localparam int QW   = quot_w(FRAC_BITS);
  localparam int SH   = UW + 3;
  localparam int MP_W = 2 * UW + 1;

  localparam logic [UW:0]   RECIP      = (UW + 1)'((64'd1 << SH) / 64'd5 + 64'd1);
  localparam logic [NM_W:0] NUM_BIAS   = (NM_W + 1)'(64'd3 << (FRAC_BITS - 1));
  localparam logic [P_W:0]  ROUND_HALF = (P_W + 1)'(64'd5 << (FRAC_BITS - 1));

  logic adv;

  // stage 1: magnitudes and signs
  logic [2:0][15:0] axis_in;
  logic [NM_W:0]    num_c;
  logic             v1;
  logic [NM_W-1:0]  nmag1;
  logic             nneg1;
  logic [15:0]      amag1 [3];
  logic             aneg1 [3];

  // stage 2: product rounded and shifted down
  logic [AXIS_W+NM_W-1:0] prod2 [3];
  logic [P_W:0]           sum2 [3];
  logic                   v2;
  logic [UW-1:0]          u2 [3];
  logic                   neg2 [3];

  // stage 3: divide by five through the reciprocal
  logic [MP_W-1:0] prod3 [3];
  logic            v3;
  logic [QW-1:0]   q3 [3];
  logic            neg3 [3];

  // stage 4: deadband and mix
  logic signed [QW:0]   ax [3];
  logic signed [WW-1:0] ex [3];
  logic signed [WW-1:0] mix [4];
  logic                 v4;
  logic [WW-1:0]        w4 [4];

  assign adv  = !qstat.full;
  assign busy = !adv;
  assign push = v4 && adv;

  assign axis_in = {stick_twist, stick_y, stick_x};
  assign num_c   = NUM_BIAS - {{(NM_W - 15){throttle[15]}}, throttle};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod2[i] = (AXIS_W + NM_W)'(amag1[i]) * (AXIS_W + NM_W)'(nmag1);
      sum2[i]  = (P_W + 1)'({prod2[i], 1'b0}) + ROUND_HALF;
      prod3[i] = MP_W'(u2[i]) * MP_W'(RECIP);
      if (q3[i] < QW'(deadband)) begin
        ax[i] = '0;
      end else begin
        ax[i] = neg3[i] ? -$signed({1'b0, q3[i]}) : $signed({1'b0, q3[i]});
      end
      ex[i] = WW'(ax[i]);
    end
    mix[0] =  ex[0] + ex[1] + ex[2];
    mix[1] = -ex[0] + ex[1] - ex[2];
    mix[2] = -ex[0] + ex[1] + ex[2];
    mix[3] =  ex[0] + ex[1] - ex[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nneg1 <= num_c[NM_W];
      nmag1 <= num_c[NM_W] ? NM_W'(~num_c + 1'b1) : num_c[NM_W-1:0];
      for (int i = 0; i < 3; i++) begin
        aneg1[i] <= axis_in[i][15];
        amag1[i] <= axis_in[i][15] ? 16'(-axis_in[i]) : axis_in[i];
        u2[i]    <= sum2[i][P_W:FRAC_BITS];
        // twist is negated on top of the scale sign
        neg2[i]  <= aneg1[i] ^ nneg1 ^ (i == 2);
        q3[i]    <= prod3[i][MP_W-1:SH];
        neg3[i]  <= neg2[i];
      end
      for (int j = 0; j < 4; j++) begin
        w4[j] <= mix[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      wheel[j] = w4[j];
    end
  end

endmodule

// ===== rtl/mwm_div.sv =====
`timescale 1ns / 1ps

module mwm_div #(
  parameter int FRAC_BITS = 15,
  parameter int MW = 21
) (
  input  logic                    clk,
  input  logic [MW+FRAC_BITS:0]   num,
  input  logic [MW-1:0]           den,
  output logic [FRAC_BITS:0]      quo
);

  localparam int NS = FRAC_BITS + 1;

  logic [MW-1:0]      rem [NS];
  logic [FRAC_BITS:0] low [NS];
  logic [FRAC_BITS:0] qq  [NS];
  logic [MW-1:0]      dv  [NS];

  logic [MW-1:0]      cur_rem [NS];
  logic [FRAC_BITS:0] cur_low [NS];
  logic [FRAC_BITS:0] cur_q   [NS];
  logic [MW-1:0]      cur_d   [NS];
  logic [MW:0]        trial   [NS];
  logic [MW:0]        diff    [NS];
  logic               ge      [NS];

  // one quotient bit per stage, quotient is known to fit in NS bits
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        cur_rem[k] = num[MW+FRAC_BITS:FRAC_BITS+1];
        cur_low[k] = num[FRAC_BITS:0];
        cur_q[k]   = '0;
        cur_d[k]   = den;
      end else begin
        cur_rem[k] = rem[k-1];
        cur_low[k] = low[k-1];
        cur_q[k]   = qq[k-1];
        cur_d[k]   = dv[k-1];
      end
      trial[k] = {cur_rem[k], cur_low[k][FRAC_BITS]};
      diff[k]  = trial[k] - {1'b0, cur_d[k]};
      ge[k]    = (trial[k] >= {1'b0, cur_d[k]});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      rem[k] <= ge[k] ? diff[k][MW-1:0] : trial[k][MW-1:0];
      low[k] <= {cur_low[k][FRAC_BITS-1:0], 1'b0};
      qq[k]  <= {cur_q[k][FRAC_BITS-1:0], ge[k]};
      dv[k]  <= cur_d[k];
    end
  end

  assign quo = qq[NS-1];

endmodule

// ===== rtl/mwm_back.sv =====
`timescale 1ns / 1ps

module mwm_back #(
  parameter  int FRAC_BITS = 15,
  localparam int WW = mwm_pkg::wheel_w(FRAC_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mwm_pkg::queue_stat_t qstat,
  input  logic [3:0][WW-1:0]   wheel,
  output logic                 pop,
  output logic                 done,
  output logic signed [15:0]   left_front_drive,
  output logic signed [15:0]   right_front_drive,
  output logic signed [15:0]   left_back_drive,
  output logic signed [15:0]   right_back_drive
);
  import mwm_pkg::*;

  localparam int NS = FRAC_BITS + 1;
  localparam int DW = WW + FRAC_BITS + 1;
  localparam int CW = max_int(WW, FRAC_BITS + 2);
  localparam int FW = max_int(WW, FRAC_BITS + 1) + 1;

  localparam logic [CW-1:0]        ONE       = CW'(64'd1 << FRAC_BITS);
  localparam logic signed [FW-1:0] SAT_HI    = FW'(32767);
  localparam logic signed [FW-1:0] SAT_LO    = ~SAT_HI;
  localparam logic [3:0]           LEFT_SIDE = 4'b0101;

  logic          v1;
  logic [WW-1:0] wmag1 [4];
  logic          wneg1 [4];

  logic [WW-1:0] m01;
  logic [WW-1:0] m23;
  logic [WW-1:0] mmax;
  logic          v2;
  logic [WW-1:0] wmag2 [4];
  logic          wneg2 [4];
  logic [WW-1:0] m2;
  logic          norm2;

  logic [DW-1:0]      dnum [4];
  logic [FRAC_BITS:0] quo  [4];

  logic          dv    [NS];
  logic          dnorm [NS];
  logic [WW-1:0] dmag  [NS][4];
  logic          dneg  [NS][4];

  logic [FW-1:0]        vmag [4];
  logic signed [FW-1:0] sval [4];
  logic [15:0]          sat  [4];
  logic [15:0]          drive [4];

  assign pop = !qstat.empty;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      wneg1[i] <= wheel[i][WW-1];
      wmag1[i] <= wheel[i][WW-1] ? WW'(-wheel[i]) : wheel[i];
    end
  end

  assign m01  = (wmag1[0] > wmag1[1]) ? wmag1[0] : wmag1[1];
  assign m23  = (wmag1[2] > wmag1[3]) ? wmag1[2] : wmag1[3];
  assign mmax = (m01 > m23) ? m01 : m23;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      wmag2[i] <= wmag1[i];
      wneg2[i] <= wneg1[i];
    end
    m2    <= mmax;
    norm2 <= (CW'(mmax) > ONE);
  end

  // w * one + m/2, divided by m in the pipelined dividers
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dnum[i] = DW'({wmag2[i], {FRAC_BITS{1'b0}}}) + DW'(m2[WW-1:1]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    mwm_div #(
      .FRAC_BITS(FRAC_BITS),
      .MW       (WW)
    ) u_div (
      .clk(clk),
      .num(dnum[g]),
      .den(m2),
      .quo(quo[g])
    );
  end

  // side data travels alongside the divider stages
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        dnorm[k] <= norm2;
        for (int i = 0; i < 4; i++) begin
          dmag[k][i] <= wmag2[i];
          dneg[k][i] <= wneg2[i];
        end
      end else begin
        dnorm[k] <= dnorm[k-1];
        for (int i = 0; i < 4; i++) begin
          dmag[k][i] <= dmag[k-1][i];
          dneg[k][i] <= dneg[k-1][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        dv[k] <= 1'b0;
      end
    end else begin
      v1 <= pop;
      v2 <= v1;
      for (int k = 0; k < NS; k++) begin
        dv[k] <= (k == 0) ? v2 : dv[k-1];
      end
      done <= dv[NS-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vmag[i] = dnorm[NS-1] ? FW'(quo[i]) : FW'(dmag[NS-1][i]);
      if (dneg[NS-1][i] ^ LEFT_SIDE[i]) begin
        sval[i] = -$signed(vmag[i]);
      end else begin
        sval[i] = $signed(vmag[i]);
      end
      if (sval[i] > SAT_HI) begin
        sat[i] = 16'h7fff;
      end else if (sval[i] < SAT_LO) begin
        sat[i] = 16'h8000;
      end else begin
        sat[i] = sval[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      drive[i] <= sat[i];
    end
  end

  assign left_front_drive  = drive[0];
  assign right_front_drive = drive[1];
  assign left_back_drive   = drive[2];
  assign right_back_drive  = drive[3];

endmodule

// ===== rtl/mecanum_wheel_mixer_unit.sv =====
`timescale 1ns / 1ps
// an accepted request reaches done through the four scaling stages, the queue, the back end
// magnitude and maximum registers, one divider stage per quotient bit and the done register
// throughput: one request per cycle; busy rises only if the front/back queue fills,
// which does not happen since the back end drains it every cycle
// reset: clears all pipeline and queue valid state and loads deadband with 4915 (0.15)
module mecanum_wheel_mixer_unit #(
  parameter int FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic signed [15:0] stick_twist,
  input  logic signed [15:0] throttle,
  output logic               done,
  output logic signed [15:0] left_front_drive,
  output logic signed [15:0] right_front_drive,
  output logic signed [15:0] left_back_drive,
  output logic signed [15:0] right_back_drive,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mwm_pkg::*;

  localparam int WW = wheel_w(FRAC_BITS);

  logic [14:0]        deadband;
  logic               reg_hit;
  logic               push;
  logic               pop;
  logic [3:0][WW-1:0] wheel_in;
  logic [3:0][WW-1:0] wheel_out;
  queue_stat_t        qstat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'(REG_DEADBAND));
  assign prdata  = reg_hit ? {17'b0, deadband} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DEADBAND_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      deadband <= pwdata[14:0];
    end
  end

  mwm_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .stick_x    (stick_x),
    .stick_y    (stick_y),
    .stick_twist(stick_twist),
    .throttle   (throttle),
    .deadband   (deadband),
    .qstat      (qstat),
    .push       (push),
    .wheel      (wheel_in)
  );

  mwm_queue #(
    .W(4 * WW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(wheel_in),
    .pop  (pop),
    .rdata(wheel_out),
    .stat (qstat)
  );

  mwm_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .qstat            (qstat),
    .wheel            (wheel_out),
    .pop              (pop),
    .done             (done),
    .left_front_drive (left_front_drive),
    .right_front_drive(right_front_drive),
    .left_back_drive  (left_back_drive),
    .right_back_drive (right_back_drive)
  );

endmodule
